>>> rtl/core/msc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Masonry column placer package
// Shared constants, payload types, register codes and sequencer states.
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam int MAX_COLUMNS = 16;
  localparam int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);
  localparam int MULP_W      = CNT_W + 8;
  localparam int XPROD_W     = COL_W + 15;
  localparam int WN_W        = 18;
  localparam int DIV_W       = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_W);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int H_W         = 24;
  localparam int X_W         = 14;

  localparam logic [H_W-1:0] H_MAX        = 24'hFFFFFF;
  localparam int             X_MAX        = 16383;
  localparam logic [H_W-1:0] HEIGHT_RESET = 24'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEWPORT_WIDTH  = 3'd0,
    REG_VIEWPORT_HEIGHT = 3'd1,
    REG_SIDE_MARGIN     = 3'd2,
    REG_TOP_MARGIN      = 3'd3,
    REG_HORIZONTAL_GAP  = 3'd4,
    REG_VERTICAL_GAP    = 3'd5,
    REG_MIN_ITEM_WIDTH  = 3'd6
  } msc_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CDIV,
    S_WMUL,
    S_WSUB,
    S_WDIV,
    S_SCAN,
    S_PLACE,
    S_OUT
  } msc_state_e;

  typedef struct packed {
    logic [15:0] item_height;
    logic        first_item;
    logic        last_item;
  } msc_item_t;

  typedef struct packed {
    logic [X_W-1:0] pos_x;
    logic [H_W-1:0] pos_y;
    logic [X_W-1:0] width_out;
    logic [3:0]     column_index;
    logic [H_W-1:0] content_height;
    logic [H_W-1:0] scroll_max;
    logic           pass_done;
  } msc_result_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } msc_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } msc_div_rsp_t;

endpackage
`default_nettype wire

>>> rtl/core/msc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Masonry column placer channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface msc_item_if;
  import msc_pkg::*;
  logic      valid;
  logic      ready;
  msc_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface msc_result_if;
  import msc_pkg::*;
  logic        valid;
  logic        ready;
  msc_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface msc_cfg_if;
  import msc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/msc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Masonry column placer divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msc_div
  import msc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire msc_div_req_t req_i,
  output msc_div_rsp_t      rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIV_W-1:0]     dvs_q, dvs_d;
  logic [DIV_W:0]       trial;
  logic                 fits;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[DIV_W-1]};
    fits   = trial >= {1'b0, dvs_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? DIV_W'(trial - {1'b0, dvs_q}) : trial[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

>>> rtl/core/masonry_shortest_column_placer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Masonry shortest column placer
// Places each item into the shortest column and reports its geometry.
// ----------------------------------------------------------------------------
// An item that does not start a pass goes from acceptance through the scan,
// place and output steps to its result; one sequencer reads one column
// height per cycle to find the shortest and the tallest column. The first item
// of a pass adds up to two runs of the shared one-bit-per-cycle divider, which
// work out the column count and the item width. One item is in work at a
// time; the result register lets the next item be accepted while a finished
// result waits. Register writes are taken at any time.
module masonry_shortest_column_placer_top
  import msc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  msc_cfg_if.sink      cfg_i,
  msc_item_if.sink     item_i,
  msc_result_if.source result_o
);

  logic [13:0] vw_q, vh_q;
  logic [7:0]  sm_q, tm_q, hg_q, vg_q;
  logic [11:0] miw_q;

  msc_state_e state_q, state_d;

  logic [H_W-1:0]     heights_q [MAX_COLUMNS];
  logic [H_W-1:0]     heights_d [MAX_COLUMNS];
  logic [CNT_W-1:0]   colcnt_q, colcnt_d;
  logic [X_W-1:0]     width_q, width_d;
  logic [15:0]        hgt_q, hgt_d;
  logic               last_q, last_d;
  logic [COL_W-1:0]   idx_q, idx_d;
  logic [COL_W-1:0]   minidx_q, minidx_d;
  logic [H_W-1:0]     minv_q, minv_d;
  logic [H_W-1:0]     maxv_q, maxv_d;
  logic [MULP_W-1:0]  mulp_q, mulp_d;
  logic [XPROD_W-1:0] xprod_q, xprod_d;
  logic [H_W-1:0]     content_q, content_d;
  msc_result_t        out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic signed [15:0]     avail;
  logic signed [15:0]     num;
  logic [15:0]            den;
  logic signed [WN_W-1:0] wnum;
  logic [WN_W-1:0]        wn2;
  logic [H_W-1:0]         cur_h;
  logic [H_W:0]           grow_sum;
  logic [H_W-1:0]         new_h;
  logic [H_W-1:0]         tallest;
  logic [H_W:0]           content_sum;
  logic [XPROD_W:0]       x_sum;
  logic [COL_W-1:0]       last_idx;
  logic [DIV_W-1:0]       wq;

  msc_div_req_t div_req;
  msc_div_rsp_t div_rsp;

  msc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw_q  <= 14'd800;
      vh_q  <= 14'd600;
      sm_q  <= 8'd16;
      tm_q  <= 8'd16;
      hg_q  <= 8'd12;
      vg_q  <= 8'd12;
      miw_q <= 12'd200;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_VIEWPORT_WIDTH:  vw_q  <= cfg_i.data[13:0];
        REG_VIEWPORT_HEIGHT: vh_q  <= cfg_i.data[13:0];
        REG_SIDE_MARGIN:     sm_q  <= cfg_i.data[7:0];
        REG_TOP_MARGIN:      tm_q  <= cfg_i.data[7:0];
        REG_HORIZONTAL_GAP:  hg_q  <= cfg_i.data[7:0];
        REG_VERTICAL_GAP:    vg_q  <= cfg_i.data[7:0];
        REG_MIN_ITEM_WIDTH:  miw_q <= cfg_i.data[11:0];
        default: begin
        end
      endcase
    end
  end

  assign avail    = $signed({2'b00, vw_q}) - $signed({7'd0, sm_q, 1'b0});
  assign num      = avail + $signed({8'd0, hg_q});
  assign den      = {4'd0, miw_q} + {8'd0, hg_q};
  assign wnum     = WN_W'(avail) - $signed(WN_W'(mulp_q));
  assign wn2      = {wnum[WN_W-2:0], 1'b0} + WN_W'(colcnt_q);
  assign cur_h    = heights_q[idx_q];
  assign last_idx = COL_W'(colcnt_q - CNT_W'(1));
  assign wq       = (div_rsp.quotient < DIV_W'(miw_q)) ? DIV_W'(miw_q) : div_rsp.quotient;

  assign grow_sum    = {1'b0, minv_q} + (H_W+1)'(hgt_q) + (H_W+1)'(vg_q);
  assign new_h       = grow_sum[H_W] ? H_MAX : grow_sum[H_W-1:0];
  assign tallest     = (new_h > maxv_q) ? new_h : maxv_q;
  assign content_sum = {1'b0, tallest} + (H_W+1)'(sm_q);
  assign x_sum       = (XPROD_W+1)'(sm_q) + (XPROD_W+1)'(xprod_q);

  always_comb begin
    state_d     = state_q;
    heights_d   = heights_q;
    colcnt_d    = colcnt_q;
    width_d     = width_q;
    hgt_d       = hgt_q;
    last_d      = last_q;
    idx_d       = idx_q;
    minidx_d    = minidx_q;
    minv_d      = minv_q;
    maxv_d      = maxv_q;
    mulp_d      = mulp_q;
    xprod_d     = xprod_q;
    content_d   = content_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !result_o.ready;
    div_req     = '0;
    item_i.ready = 1'b0;

    case (state_q)
      S_IDLE: begin
        item_i.ready = 1'b1;
        if (item_i.valid) begin
          hgt_d  = item_i.data.item_height;
          last_d = item_i.data.last_item;
          idx_d  = '0;
          if (item_i.data.first_item) begin
            for (int i = 0; i < MAX_COLUMNS; i++) begin
              heights_d[i] = H_W'(tm_q);
            end
            if (den == '0) begin
              colcnt_d = CNT_W'(MAX_COLUMNS);
              state_d  = S_WMUL;
            end else if (num[15] || num == '0) begin
              colcnt_d = CNT_W'(1);
              state_d  = S_WMUL;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = DIV_W'(num);
              div_req.divisor  = den;
              state_d          = S_CDIV;
            end
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_CDIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient == '0) begin
            colcnt_d = CNT_W'(1);
          end else if (div_rsp.quotient > DIV_W'(MAX_COLUMNS)) begin
            colcnt_d = CNT_W'(MAX_COLUMNS);
          end else begin
            colcnt_d = CNT_W'(div_rsp.quotient);
          end
          state_d = S_WMUL;
        end
      end
      S_WMUL: begin
        mulp_d  = MULP_W'(colcnt_q - CNT_W'(1)) * MULP_W'(hg_q);
        state_d = S_WSUB;
      end
      S_WSUB: begin
        if (wnum[WN_W-1]) begin
          width_d = X_W'(miw_q);
          state_d = S_SCAN;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(wn2);
          div_req.divisor  = DIV_W'({colcnt_q, 1'b0});
          state_d          = S_WDIV;
        end
      end
      S_WDIV: begin
        if (div_rsp.done) begin
          width_d = X_W'(wq);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_q == '0) begin
          minv_d   = cur_h;
          minidx_d = '0;
          maxv_d   = cur_h;
        end else begin
          if (cur_h < minv_q) begin
            minv_d   = cur_h;
            minidx_d = idx_q;
          end
          if (cur_h > maxv_q) begin
            maxv_d = cur_h;
          end
        end
        if (idx_q == last_idx) begin
          state_d = S_PLACE;
        end else begin
          idx_d = idx_q + COL_W'(1);
        end
      end
      S_PLACE: begin
        heights_d[minidx_q] = new_h;
        content_d = content_sum[H_W] ? H_MAX : content_sum[H_W-1:0];
        xprod_d   = XPROD_W'(minidx_q) * XPROD_W'({1'b0, width_q} + 15'(hg_q));
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || result_o.ready) begin
          out_d.pos_x          = (x_sum > (XPROD_W+1)'(X_MAX)) ? X_W'(X_MAX) : X_W'(x_sum);
          out_d.pos_y          = minv_q;
          out_d.width_out      = width_q;
          out_d.column_index   = 4'(minidx_q);
          out_d.content_height = content_q;
          out_d.scroll_max     = (content_q > H_W'(vh_q)) ? content_q - H_W'(vh_q) : '0;
          out_d.pass_done      = last_q;
          out_valid_d          = 1'b1;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      colcnt_q    <= CNT_W'(1);
      width_q     <= '0;
      for (int i = 0; i < MAX_COLUMNS; i++) begin
        heights_q[i] <= HEIGHT_RESET;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      colcnt_q    <= colcnt_d;
      width_q     <= width_d;
      heights_q   <= heights_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hgt_q     <= hgt_d;
    last_q    <= last_d;
    idx_q     <= idx_d;
    minidx_q  <= minidx_d;
    minv_q    <= minv_d;
    maxv_q    <= maxv_d;
    mulp_q    <= mulp_d;
    xprod_q   <= xprod_d;
    content_q <= content_d;
    out_q     <= out_d;
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  // The column count always stays within one and the number of columns built.
  a_colcnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    colcnt_q != '0 && colcnt_q <= CNT_W'(MAX_COLUMNS))
    else $error("column count out of range");

  // The scan never reads a column beyond the active count.
  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> idx_q <= last_idx)
    else $error("scan index beyond active columns");

  // A division finishes only while the sequencer waits for one.
  a_div_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_CDIV || state_q == S_WDIV))
    else $error("divider result with no waiting step");

  // A new result is loaded only from the output step.
  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result loaded outside the output step");

endmodule
`default_nettype wire
